// ===== rtl/core/sse_pkg.sv =====
`default_nettype none
package sse_pkg;

  localparam int MAX_LINES    = 256;
  localparam int LINE_W       = $clog2(MAX_LINES);
  localparam int POOL_ENTRIES = 1024;
  localparam int POOL_W       = $clog2(POOL_ENTRIES);
  localparam int PTR_W        = POOL_W + 1;
  localparam int CNT_W        = POOL_W + 1;
  localparam int LC_W         = 9;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic signed [15:0] coord_t;

  localparam ptr_t NIL = '1;

  localparam logic [2:0] F_ADD   = 3'd0;
  localparam logic [2:0] F_DEL   = 3'd1;
  localparam logic [2:0] F_READ  = 3'd2;
  localparam logic [2:0] F_RANGE = 3'd3;
  localparam logic [2:0] F_CLEAR = 3'd4;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_OUTSIDE = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_NOSPAN  = 2'd3;

  localparam logic [1:0] CFG_TOP_LINE   = 2'd0;
  localparam logic [1:0] CFG_LINE_COUNT = 2'd1;

  typedef struct packed {
    coord_t left;
    coord_t right;
    ptr_t   link;
  } pool_ent_t;

  typedef struct packed {
    logic              we;
    logic [POOL_W-1:0] addr;
    pool_ent_t         ent;
  } pool_wr_t;

  typedef struct packed {
    logic head_we;
    logic tail_we;
    logic ne_we;
    logic ne_val;
    logic clear;
    ptr_t head;
    ptr_t tail;
  } line_wr_t;

  function automatic logic is_live(ptr_t p);
    return ~p[PTR_W-1];
  endfunction

  function automatic logic signed [16:0] ext17(coord_t v);
    return $signed({v[15], v});
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sse_line_store.sv =====
`default_nettype none
module sse_line_store (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        rd_en,
  input  wire [sse_pkg::LINE_W-1:0]  rd_idx,
  input  wire [sse_pkg::LINE_W-1:0]  wr_idx,
  input  sse_pkg::line_wr_t          wr,
  input  wire [sse_pkg::LINE_W-1:0]  scan_idx,
  output sse_pkg::ptr_t              head_q,
  output sse_pkg::ptr_t              tail_q,
  output logic                       ne_q,
  output logic                       scan_ne
);
  import sse_pkg::*;

  ptr_t head_mem [MAX_LINES];
  ptr_t tail_mem [MAX_LINES];
  logic [MAX_LINES-1:0] ne_r;

  always_ff @(posedge clk) begin
    if (!rst_n || wr.clear) begin
      ne_r <= '0;
    end else if (wr.ne_we) begin
      ne_r[wr_idx] <= wr.ne_val;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.head_we) begin
      head_mem[wr_idx] <= wr.head;
    end
    if (wr.tail_we) begin
      tail_mem[wr_idx] <= wr.tail;
    end
    if (rd_en) begin
      head_q <= head_mem[rd_idx];
      tail_q <= tail_mem[rd_idx];
      ne_q   <= ne_r[rd_idx];
    end
  end

  assign scan_ne = ne_r[scan_idx];

endmodule
`default_nettype wire

// ===== rtl/core/sse_pool_store.sv =====
`default_nettype none
module sse_pool_store (
  input  wire                        clk,
  input  wire                        rd_en,
  input  wire [sse_pkg::POOL_W-1:0]  rd_addr,
  input  sse_pkg::pool_wr_t          wr,
  output sse_pkg::pool_ent_t         rd_data
);
  import sse_pkg::*;

  pool_ent_t mem [POOL_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.ent;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/scanline_span_set_engine_core.sv =====
`default_nettype none
// Per-scanline sorted span sets in a shared pool of 1024 span entries. Line heads
// and tails sit in one line memory, span ends and links in the pool memory, both
// with registered reads. An operation reads the line, then takes in each span entry
// it visits or frees on the line (the read of the next entry is issued as each one
// is taken in), with a tail check first for an add to a non-empty line, and with an
// allocation and commit when an entry is allocated for an add or a split. Range
// scans the line occupancy flags one line a cycle, up to twice the window height.
// Clear and register writes take effect without a walk over the lines. A result is
// held in an output register, so the next transaction is taken while it waits.
module scanline_span_set_engine_core (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [2:0]  in_func,
  input  wire  [15:0] in_line_y,
  input  wire  [15:0] in_left_x,
  input  wire  [15:0] in_right_x,
  input  wire  [9:0]  in_span_index,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_span_left,
  output logic [15:0] out_span_right,
  output logic [10:0] out_span_count,
  output logic [15:0] out_first_line,
  output logic [15:0] out_last_line,
  output logic [10:0] out_used_entries,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [15:0] cfg_data
);
  import sse_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE    = 15'h0001,
    S_LINE    = 15'h0002,
    S_ADD_T   = 15'h0004,
    S_ADD_W   = 15'h0008,
    S_MRG_W   = 15'h0010,
    S_MRG_FIN = 15'h0020,
    S_ALLOC   = 15'h0040,
    S_ALLOC_W = 15'h0080,
    S_COMMIT  = 15'h0100,
    S_COMMIT2 = 15'h0200,
    S_DEL_W   = 15'h0400,
    S_DEL_GB  = 15'h0800,
    S_READ_W  = 15'h1000,
    S_RANGE   = 15'h2000,
    S_RESP    = 15'h4000
  } state_t;

  typedef enum logic [1:0] {
    K_EMPTY  = 2'd0,
    K_APPEND = 2'd1,
    K_BEFORE = 2'd2,
    K_SPLIT  = 2'd3
  } kind_t;

  state_t state_r, state_nxt;
  kind_t  kind_r, kind_nxt;
  logic [2:0]        func_r, func_nxt;
  logic [LINE_W-1:0] li_r, li_nxt;
  logic              inwin_r, inwin_nxt;
  coord_t            xl_r, xl_nxt, xr_r, xr_nxt;
  logic [9:0]        want_r, want_nxt;
  ptr_t              cur_r, cur_nxt, prev_r, prev_nxt, e_r, e_nxt, clink_r, clink_nxt;
  coord_t            cl_r, cl_nxt, cr_r, cr_nxt, pl_r, pl_nxt, pr_r, pr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [1:0]        status_r, status_nxt;
  coord_t            sl_r, sl_nxt, sr_r, sr_nxt, fl_r, fl_nxt, ll_r, ll_nxt;
  logic [CNT_W-1:0]  fresh_r, fresh_nxt, live_r, live_nxt;
  ptr_t              rec_r, rec_nxt;
  logic [LINE_W-1:0] scan_r, scan_nxt;
  logic              up_r, up_nxt;
  coord_t            top_r, top_nxt;
  logic [LC_W-1:0]   lc_r, lc_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        o_status_r, o_status_nxt;
  coord_t            o_sl_r, o_sl_nxt, o_sr_r, o_sr_nxt, o_fl_r, o_fl_nxt, o_ll_r, o_ll_nxt;
  logic [CNT_W-1:0]  o_cnt_r, o_cnt_nxt, o_used_r, o_used_nxt;

  logic              line_rd_en;
  line_wr_t          lw;
  ptr_t              head_q, tail_q;
  logic              ne_q, scan_ne;
  logic              pr_en;
  logic [POOL_W-1:0] pr_addr;
  pool_wr_t          pw;
  pool_ent_t         rd;

  logic [LC_W-1:0]   n_lines;
  logic [LINE_W-1:0] last_idx;
  logic [16:0]       dy;
  logic              in_win;
  logic              in_acc, cfg_acc;
  logic signed [16:0] rl17, rr17, cr17, xl17, xr17;

  sse_line_store u_line (
    .clk(clk), .rst_n(rst_n), .rd_en(line_rd_en), .rd_idx(dy[LINE_W-1:0]),
    .wr_idx(li_r), .wr(lw), .scan_idx(scan_r),
    .head_q(head_q), .tail_q(tail_q), .ne_q(ne_q), .scan_ne(scan_ne)
  );

  sse_pool_store u_pool (
    .clk(clk), .rd_en(pr_en), .rd_addr(pr_addr), .wr(pw), .rd_data(rd)
  );

  assign n_lines  = (lc_r > LC_W'(MAX_LINES)) ? LC_W'(MAX_LINES) : lc_r;
  assign last_idx = LINE_W'(n_lines - LC_W'(1));
  assign dy       = {in_line_y[15], in_line_y} - {top_r[15], top_r};
  assign in_win   = ~dy[16] && (dy < {{(17-LC_W){1'b0}}, n_lines});
  assign in_ready = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign cfg_acc  = cfg_valid && cfg_ready;
  assign line_rd_en = in_acc;

  assign rl17 = ext17(rd.left);
  assign rr17 = ext17(rd.right);
  assign cr17 = ext17(cr_r);
  assign xl17 = ext17(xl_r);
  assign xr17 = ext17(xr_r);

  always_comb begin
    state_nxt = state_r;  kind_nxt = kind_r;    func_nxt = func_r;
    li_nxt = li_r;        inwin_nxt = inwin_r;  xl_nxt = xl_r;     xr_nxt = xr_r;
    want_nxt = want_r;    cur_nxt = cur_r;      prev_nxt = prev_r; e_nxt = e_r;
    clink_nxt = clink_r;  cl_nxt = cl_r;        cr_nxt = cr_r;     pl_nxt = pl_r;
    pr_nxt = pr_r;        cnt_nxt = cnt_r;      status_nxt = status_r;
    sl_nxt = sl_r;        sr_nxt = sr_r;        fl_nxt = fl_r;     ll_nxt = ll_r;
    fresh_nxt = fresh_r;  live_nxt = live_r;    rec_nxt = rec_r;
    scan_nxt = scan_r;    up_nxt = up_r;        top_nxt = top_r;   lc_nxt = lc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    o_status_nxt = o_status_r; o_sl_nxt = o_sl_r; o_sr_nxt = o_sr_r;
    o_fl_nxt = o_fl_r; o_ll_nxt = o_ll_r; o_cnt_nxt = o_cnt_r; o_used_nxt = o_used_r;
    lw = '0;
    pw = '0;
    pr_en = 1'b0;
    pr_addr = '0;

    unique case (state_r)
      S_IDLE: begin
        if (cfg_acc) begin
          if (cfg_index == CFG_TOP_LINE) begin
            top_nxt = cfg_data;
          end
          if (cfg_index == CFG_LINE_COUNT) begin
            lc_nxt = cfg_data[LC_W-1:0];
          end
          if (cfg_index == CFG_TOP_LINE || cfg_index == CFG_LINE_COUNT) begin
            lw.clear  = 1'b1;
            fresh_nxt = '0;
            live_nxt  = '0;
            rec_nxt   = NIL;
          end
        end
        if (in_acc) begin
          func_nxt = in_func;
          li_nxt = dy[LINE_W-1:0];
          inwin_nxt = in_win;
          xl_nxt = in_left_x;
          xr_nxt = in_right_x;
          want_nxt = in_span_index;
          status_nxt = ST_DONE;
          cnt_nxt = '0;
          sl_nxt = '0; sr_nxt = '0; fl_nxt = '0; ll_nxt = '0;
          state_nxt = S_LINE;
        end
      end

      S_LINE: begin
        state_nxt = S_RESP;
        prev_nxt = NIL;
        unique case (func_r)
          F_ADD: begin
            if (!inwin_r) begin
              status_nxt = ST_OUTSIDE;
            end else if (xl_r <= xr_r) begin
              if (!ne_q) begin
                kind_nxt = K_EMPTY;
                state_nxt = S_ALLOC;
              end else begin
                cur_nxt = tail_q;
                pr_en = 1'b1;
                pr_addr = tail_q[POOL_W-1:0];
                state_nxt = S_ADD_T;
              end
            end
          end
          F_DEL: begin
            if (!inwin_r) begin
              status_nxt = ST_OUTSIDE;
            end else if (xl_r <= xr_r && ne_q) begin
              cur_nxt = head_q;
              pr_en = 1'b1;
              pr_addr = head_q[POOL_W-1:0];
              state_nxt = S_DEL_W;
            end
          end
          F_READ: begin
            if (!inwin_r) begin
              status_nxt = ST_OUTSIDE;
            end else begin
              status_nxt = ST_NOSPAN;
              if (ne_q) begin
                pr_en = 1'b1;
                pr_addr = head_q[POOL_W-1:0];
                state_nxt = S_READ_W;
              end
            end
          end
          F_RANGE: begin
            if (n_lines == '0) begin
              fl_nxt = top_r;
              ll_nxt = top_r;
            end else begin
              scan_nxt = '0;
              up_nxt = 1'b1;
              state_nxt = S_RANGE;
            end
          end
          F_CLEAR: begin
            lw.clear  = 1'b1;
            fresh_nxt = '0;
            live_nxt  = '0;
            rec_nxt   = NIL;
          end
          default: begin
          end
        endcase
      end

      S_ADD_T: begin
        cl_nxt = rd.left;
        cr_nxt = rd.right;
        if (xl17 > rr17 + 17'sd1) begin
          kind_nxt = K_APPEND;
          state_nxt = S_ALLOC;
        end else begin
          cur_nxt = head_q;
          pr_en = 1'b1;
          pr_addr = head_q[POOL_W-1:0];
          state_nxt = S_ADD_W;
        end
      end

      S_ADD_W: begin
        cl_nxt = rd.left;
        cr_nxt = rd.right;
        clink_nxt = rd.link;
        if (xr17 < rl17 - 17'sd1) begin
          kind_nxt = K_BEFORE;
          state_nxt = S_ALLOC;
        end else if (xr_r <= rd.right) begin
          if (xl_r < rd.left) begin
            pw.we = 1'b1;
            pw.addr = cur_r[POOL_W-1:0];
            pw.ent = '{left: xl_r, right: rd.right, link: rd.link};
          end
          state_nxt = S_RESP;
        end else if (xl17 <= rr17 + 17'sd1) begin
          if (xl_r < rd.left) begin
            cl_nxt = xl_r;
          end
          cr_nxt = xr_r;
          if (is_live(rd.link)) begin
            e_nxt = rd.link;
            pr_en = 1'b1;
            pr_addr = rd.link[POOL_W-1:0];
            state_nxt = S_MRG_W;
          end else begin
            state_nxt = S_MRG_FIN;
          end
        end else if (!is_live(rd.link)) begin
          kind_nxt = K_APPEND;
          state_nxt = S_ALLOC;
        end else begin
          prev_nxt = cur_r;
          pl_nxt = rd.left;
          pr_nxt = rd.right;
          cur_nxt = rd.link;
          pr_en = 1'b1;
          pr_addr = rd.link[POOL_W-1:0];
          state_nxt = S_ADD_W;
        end
      end

      S_MRG_W: begin
        if (rl17 <= cr17 + 17'sd1) begin
          if (rd.right > cr_r) begin
            cr_nxt = rd.right;
          end
          clink_nxt = rd.link;
          pw.we = 1'b1;
          pw.addr = e_r[POOL_W-1:0];
          pw.ent = '{left: rd.left, right: rd.right, link: rec_r};
          rec_nxt = e_r;
          if (live_r != '0) begin
            live_nxt = live_r - CNT_W'(1);
          end
          if (is_live(rd.link)) begin
            e_nxt = rd.link;
            pr_en = 1'b1;
            pr_addr = rd.link[POOL_W-1:0];
          end else begin
            state_nxt = S_MRG_FIN;
          end
        end else begin
          state_nxt = S_MRG_FIN;
        end
      end

      S_MRG_FIN: begin
        pw.we = 1'b1;
        pw.addr = cur_r[POOL_W-1:0];
        pw.ent = '{left: cl_r, right: cr_r, link: clink_r};
        if (!is_live(clink_r)) begin
          lw.tail_we = 1'b1;
          lw.tail = cur_r;
        end
        state_nxt = S_RESP;
      end

      S_ALLOC: begin
        if (fresh_r < CNT_W'(POOL_ENTRIES)) begin
          e_nxt = ptr_t'(fresh_r);
          fresh_nxt = fresh_r + CNT_W'(1);
          live_nxt = live_r + CNT_W'(1);
          state_nxt = S_COMMIT;
        end else if (is_live(rec_r)) begin
          pr_en = 1'b1;
          pr_addr = rec_r[POOL_W-1:0];
          state_nxt = S_ALLOC_W;
        end else begin
          status_nxt = ST_FULL;
          state_nxt = S_RESP;
        end
      end

      S_ALLOC_W: begin
        e_nxt = rec_r;
        rec_nxt = rd.link;
        live_nxt = live_r + CNT_W'(1);
        state_nxt = S_COMMIT;
      end

      S_COMMIT: begin
        pw.we = 1'b1;
        pw.addr = e_r[POOL_W-1:0];
        pw.ent = '{left: xl_r, right: xr_r, link: NIL};
        state_nxt = S_COMMIT2;
        unique case (kind_r)
          K_EMPTY: begin
            lw.head_we = 1'b1;
            lw.tail_we = 1'b1;
            lw.ne_we = 1'b1;
            lw.ne_val = 1'b1;
            lw.head = e_r;
            lw.tail = e_r;
            state_nxt = S_RESP;
          end
          K_APPEND: begin
            lw.tail_we = 1'b1;
            lw.tail = e_r;
          end
          K_BEFORE: begin
            pw.ent.link = cur_r;
            if (!is_live(prev_r)) begin
              lw.head_we = 1'b1;
              lw.head = e_r;
              state_nxt = S_RESP;
            end
          end
          K_SPLIT: begin
            pw.ent = '{left: xr_r + 16'sd1, right: cr_r, link: clink_r};
          end
        endcase
      end

      S_COMMIT2: begin
        pw.we = 1'b1;
        state_nxt = S_RESP;
        unique case (kind_r)
          K_BEFORE: begin
            pw.addr = prev_r[POOL_W-1:0];
            pw.ent = '{left: pl_r, right: pr_r, link: e_r};
          end
          K_SPLIT: begin
            pw.addr = cur_r[POOL_W-1:0];
            pw.ent = '{left: cl_r, right: xl_r - 16'sd1, link: e_r};
            prev_nxt = e_r;
            pl_nxt = xr_r + 16'sd1;
            pr_nxt = cr_r;
            cur_nxt = clink_r;
            if (is_live(clink_r)) begin
              pr_en = 1'b1;
              pr_addr = clink_r[POOL_W-1:0];
              state_nxt = S_DEL_W;
            end else begin
              lw.tail_we = 1'b1;
              lw.tail = e_r;
            end
          end
          default: begin
            pw.addr = cur_r[POOL_W-1:0];
            pw.ent = '{left: cl_r, right: cr_r, link: e_r};
          end
        endcase
      end

      S_DEL_W: begin
        cl_nxt = rd.left;
        cr_nxt = rd.right;
        clink_nxt = rd.link;
        if (xr_r < rd.left) begin
          state_nxt = S_RESP;
        end else if (xl_r <= rd.left && xr_r >= rd.right) begin
          if (is_live(prev_r)) begin
            pw.we = 1'b1;
            pw.addr = prev_r[POOL_W-1:0];
            pw.ent = '{left: pl_r, right: pr_r, link: rd.link};
          end else begin
            lw.head_we = 1'b1;
            lw.head = rd.link;
            lw.ne_we = 1'b1;
            lw.ne_val = is_live(rd.link);
          end
          state_nxt = S_DEL_GB;
        end else if (xl_r > rd.left && xr_r < rd.right) begin
          kind_nxt = K_SPLIT;
          state_nxt = S_ALLOC;
        end else begin
          prev_nxt = cur_r;
          pl_nxt = rd.left;
          pr_nxt = rd.right;
          if (xl_r >= rd.left && xl_r <= rd.right && xr_r >= rd.right) begin
            pr_nxt = xl_r - 16'sd1;
          end else if (xr_r >= rd.left && xr_r <= rd.right && xl_r <= rd.left) begin
            pl_nxt = xr_r + 16'sd1;
          end
          pw.we = 1'b1;
          pw.addr = cur_r[POOL_W-1:0];
          pw.ent = '{left: pl_nxt, right: pr_nxt, link: rd.link};
          cur_nxt = rd.link;
          if (is_live(rd.link)) begin
            pr_en = 1'b1;
            pr_addr = rd.link[POOL_W-1:0];
          end else begin
            lw.tail_we = 1'b1;
            lw.tail = cur_r;
            state_nxt = S_RESP;
          end
        end
      end

      S_DEL_GB: begin
        pw.we = 1'b1;
        pw.addr = cur_r[POOL_W-1:0];
        pw.ent = '{left: cl_r, right: cr_r, link: rec_r};
        rec_nxt = cur_r;
        if (live_r != '0) begin
          live_nxt = live_r - CNT_W'(1);
        end
        cur_nxt = clink_r;
        if (is_live(clink_r)) begin
          pr_en = 1'b1;
          pr_addr = clink_r[POOL_W-1:0];
          state_nxt = S_DEL_W;
        end else begin
          lw.tail_we = 1'b1;
          lw.tail = prev_r;
          state_nxt = S_RESP;
        end
      end

      S_READ_W: begin
        if (cnt_r == {1'b0, want_r}) begin
          sl_nxt = rd.left;
          sr_nxt = rd.right;
          status_nxt = ST_DONE;
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (is_live(rd.link) && cnt_nxt < CNT_W'(POOL_ENTRIES)) begin
          pr_en = 1'b1;
          pr_addr = rd.link[POOL_W-1:0];
        end else begin
          state_nxt = S_RESP;
        end
      end

      S_RANGE: begin
        if (up_r) begin
          if (scan_r < last_idx && !scan_ne) begin
            scan_nxt = scan_r + LINE_W'(1);
          end else begin
            fl_nxt = top_r + $signed(16'(scan_r));
            scan_nxt = last_idx;
            up_nxt = 1'b0;
          end
        end else begin
          if (scan_r != '0 && !scan_ne) begin
            scan_nxt = scan_r - LINE_W'(1);
          end else begin
            ll_nxt = top_r + $signed(16'(scan_r));
            state_nxt = S_RESP;
          end
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          o_status_nxt = status_r;
          o_sl_nxt = sl_r;
          o_sr_nxt = sr_r;
          o_cnt_nxt = cnt_r;
          o_fl_nxt = fl_r;
          o_ll_nxt = ll_r;
          o_used_nxt = live_r;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      fresh_r <= '0;
      live_r <= '0;
      rec_r <= NIL;
      top_r <= '0;
      lc_r <= LC_W'(MAX_LINES);
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      fresh_r <= fresh_nxt;
      live_r <= live_nxt;
      rec_r <= rec_nxt;
      top_r <= top_nxt;
      lc_r <= lc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;     func_r <= func_nxt;   li_r <= li_nxt;
    inwin_r <= inwin_nxt;   xl_r <= xl_nxt;       xr_r <= xr_nxt;
    want_r <= want_nxt;     cur_r <= cur_nxt;     prev_r <= prev_nxt;
    e_r <= e_nxt;           clink_r <= clink_nxt; cl_r <= cl_nxt;
    cr_r <= cr_nxt;         pl_r <= pl_nxt;       pr_r <= pr_nxt;
    cnt_r <= cnt_nxt;       status_r <= status_nxt;
    sl_r <= sl_nxt;         sr_r <= sr_nxt;       fl_r <= fl_nxt;
    ll_r <= ll_nxt;         scan_r <= scan_nxt;   up_r <= up_nxt;
    o_status_r <= o_status_nxt; o_sl_r <= o_sl_nxt; o_sr_r <= o_sr_nxt;
    o_fl_r <= o_fl_nxt;     o_ll_r <= o_ll_nxt;   o_cnt_r <= o_cnt_nxt;
    o_used_r <= o_used_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = o_status_r;
  assign out_span_left    = o_sl_r;
  assign out_span_right   = o_sr_r;
  assign out_span_count   = o_cnt_r;
  assign out_first_line   = o_fl_r;
  assign out_last_line    = o_ll_r;
  assign out_used_entries = o_used_r;

endmodule
`default_nettype wire

// ===== sim/scanline_span_set_engine_core_test.sv =====
module scanline_span_set_engine_core_test;
  import sse_pkg::*;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] line_y;
    logic [15:0] left_x;
    logic [15:0] right_x;
    logic [9:0]  span_index;
  } span_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] span_left;
    logic [15:0] span_right;
    logic [10:0] span_count;
    logic [15:0] first_line;
    logic [15:0] last_line;
    logic [10:0] used_entries;
  } span_resp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  wire         in_ready;
  logic [2:0]  in_func = '0;
  logic [15:0] in_line_y = '0;
  logic [15:0] in_left_x = '0;
  logic [15:0] in_right_x = '0;
  logic [9:0]  in_span_index = '0;
  wire         out_valid;
  logic        out_ready = 1'b0;
  wire  [1:0]  out_status;
  wire  [15:0] out_span_left;
  wire  [15:0] out_span_right;
  wire  [10:0] out_span_count;
  wire  [15:0] out_first_line;
  wire  [15:0] out_last_line;
  wire  [10:0] out_used_entries;
  logic        cfg_valid = 1'b0;
  wire         cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  scanline_span_set_engine_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_line_y(in_line_y), .in_left_x(in_left_x), .in_right_x(in_right_x),
    .in_span_index(in_span_index),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_span_left(out_span_left), .out_span_right(out_span_right),
    .out_span_count(out_span_count), .out_first_line(out_first_line),
    .out_last_line(out_last_line), .out_used_entries(out_used_entries),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the span store
  int   win_top;
  int   win_lines;
  ptr_t head_of[MAX_LINES];
  ptr_t tail_of[MAX_LINES];
  int   ent_l[POOL_ENTRIES];
  int   ent_r[POOL_ENTRIES];
  ptr_t ent_nx[POOL_ENTRIES];
  int   fresh_cnt;
  ptr_t free_head;
  int   live_cnt;

  span_req_t  pending_reqs[$];
  span_resp_t expected_resps[$];
  int         n_errors = 0;
  int         n_checked = 0;
  int         n_full = 0;

  function automatic bit alive(ptr_t p);
    return !p[PTR_W-1];
  endfunction

  function automatic void wipe_store();
    for (int i = 0; i < MAX_LINES; i++) begin
      head_of[i] = NIL;
      tail_of[i] = NIL;
    end
    fresh_cnt = 0;
    free_head = NIL;
    live_cnt = 0;
  endfunction

  function automatic ptr_t grab_entry();
    ptr_t e;
    if (fresh_cnt < POOL_ENTRIES) begin
      e = ptr_t'(fresh_cnt);
      fresh_cnt++;
    end else if (alive(free_head)) begin
      e = free_head;
      free_head = ent_nx[e[POOL_W-1:0]];
    end else begin
      return NIL;
    end
    live_cnt++;
    return e;
  endfunction

  function automatic void drop_entry(ptr_t e);
    ent_nx[e[POOL_W-1:0]] = free_head;
    free_head = e;
    if (live_cnt > 0) live_cnt--;
  endfunction

  function automatic void put_span(ptr_t e, int l, int r, ptr_t nx);
    ent_l[e[POOL_W-1:0]] = l;
    ent_r[e[POOL_W-1:0]] = r;
    ent_nx[e[POOL_W-1:0]] = nx;
  endfunction

  function automatic int active_lines();
    return win_lines > MAX_LINES ? MAX_LINES : win_lines;
  endfunction

  function automatic logic [1:0] unite_span(int li, int xl, int xr);
    ptr_t e, nx, prev, cur, t;
    prev = NIL;
    cur = head_of[li];
    t = tail_of[li];
    if (!alive(cur)) begin
      e = grab_entry();
      if (!alive(e)) return ST_FULL;
      put_span(e, xl, xr, NIL);
      head_of[li] = e;
      tail_of[li] = e;
      return ST_DONE;
    end
    if (alive(t) && xl > ent_r[t[POOL_W-1:0]] + 1) begin
      e = grab_entry();
      if (!alive(e)) return ST_FULL;
      put_span(e, xl, xr, NIL);
      ent_nx[t[POOL_W-1:0]] = e;
      tail_of[li] = e;
      return ST_DONE;
    end
    while (alive(cur)) begin
      if (xr < ent_l[cur[POOL_W-1:0]] - 1) begin
        e = grab_entry();
        if (!alive(e)) return ST_FULL;
        put_span(e, xl, xr, cur);
        if (alive(prev)) ent_nx[prev[POOL_W-1:0]] = e;
        else head_of[li] = e;
        return ST_DONE;
      end
      if (xr <= ent_r[cur[POOL_W-1:0]]) begin
        if (xl < ent_l[cur[POOL_W-1:0]]) ent_l[cur[POOL_W-1:0]] = xl;
        return ST_DONE;
      end
      if (xl <= ent_r[cur[POOL_W-1:0]] + 1) begin
        if (xl < ent_l[cur[POOL_W-1:0]]) ent_l[cur[POOL_W-1:0]] = xl;
        ent_r[cur[POOL_W-1:0]] = xr;
        nx = ent_nx[cur[POOL_W-1:0]];
        while (alive(nx) && ent_l[nx[POOL_W-1:0]] <= ent_r[cur[POOL_W-1:0]] + 1) begin
          if (ent_r[nx[POOL_W-1:0]] > ent_r[cur[POOL_W-1:0]])
            ent_r[cur[POOL_W-1:0]] = ent_r[nx[POOL_W-1:0]];
          ent_nx[cur[POOL_W-1:0]] = ent_nx[nx[POOL_W-1:0]];
          drop_entry(nx);
          nx = ent_nx[cur[POOL_W-1:0]];
        end
        if (!alive(ent_nx[cur[POOL_W-1:0]])) tail_of[li] = cur;
        return ST_DONE;
      end
      if (!alive(ent_nx[cur[POOL_W-1:0]])) begin
        e = grab_entry();
        if (!alive(e)) return ST_FULL;
        put_span(e, xl, xr, NIL);
        ent_nx[cur[POOL_W-1:0]] = e;
        tail_of[li] = e;
        return ST_DONE;
      end
      prev = cur;
      cur = ent_nx[cur[POOL_W-1:0]];
    end
    return ST_DONE;
  endfunction

  function automatic logic [1:0] subtract_span(int li, int xl, int xr);
    ptr_t e, nx, prev, cur;
    int l, r;
    prev = NIL;
    cur = head_of[li];
    while (alive(cur)) begin
      l = ent_l[cur[POOL_W-1:0]];
      r = ent_r[cur[POOL_W-1:0]];
      if (xr < l) break;
      if (xl <= l && xr >= r) begin
        nx = ent_nx[cur[POOL_W-1:0]];
        if (alive(prev)) ent_nx[prev[POOL_W-1:0]] = nx;
        else head_of[li] = nx;
        drop_entry(cur);
        cur = nx;
        continue;
      end
      if (xl > l && xr < r) begin
        e = grab_entry();
        if (!alive(e)) return ST_FULL;
        put_span(e, xr + 1, r, ent_nx[cur[POOL_W-1:0]]);
        ent_r[cur[POOL_W-1:0]] = xl - 1;
        ent_nx[cur[POOL_W-1:0]] = e;
        cur = e;
      end else if (xl >= l && xl <= r && xr >= r) begin
        ent_r[cur[POOL_W-1:0]] = xl - 1;
      end else if (xr >= l && xr <= r && xl <= l) begin
        ent_l[cur[POOL_W-1:0]] = xr + 1;
      end
      prev = cur;
      cur = ent_nx[cur[POOL_W-1:0]];
    end
    if (!alive(cur)) tail_of[li] = prev;
    return ST_DONE;
  endfunction

  function automatic span_resp_t span_store_step(span_req_t q);
    span_resp_t o;
    int y, xl, xr, d, n, i, cnt;
    ptr_t cur;
    o = '0;
    y = $signed(q.line_y);
    xl = $signed(q.left_x);
    xr = $signed(q.right_x);
    if (q.func <= F_READ) begin
      d = y - win_top;
      if (d < 0 || d >= active_lines()) begin
        o.status = ST_OUTSIDE;
      end else if (q.func == F_ADD) begin
        if (xl <= xr) o.status = unite_span(d, xl, xr);
      end else if (q.func == F_DEL) begin
        if (xl <= xr) begin
          o.status = subtract_span(d, xl, xr);
          if (o.status == ST_FULL) n_full++;
        end
      end else begin
        o.status = ST_NOSPAN;
        cnt = 0;
        cur = head_of[d];
        while (alive(cur) && cnt < POOL_ENTRIES) begin
          if (cnt == q.span_index) begin
            o.span_left = 16'(ent_l[cur[POOL_W-1:0]]);
            o.span_right = 16'(ent_r[cur[POOL_W-1:0]]);
            o.status = ST_DONE;
          end
          cnt++;
          cur = ent_nx[cur[POOL_W-1:0]];
        end
        o.span_count = 11'(cnt);
      end
      if (q.func == F_ADD && o.status == ST_FULL) n_full++;
    end else if (q.func == F_RANGE) begin
      n = active_lines();
      if (n == 0) begin
        o.first_line = 16'(win_top);
        o.last_line = 16'(win_top);
      end else begin
        i = 0;
        while (i < n - 1 && !alive(head_of[i])) i++;
        o.first_line = 16'(win_top + i);
        i = n - 1;
        while (i > 0 && !alive(head_of[i])) i--;
        o.last_line = 16'(win_top + i);
      end
    end else if (q.func == F_CLEAR) begin
      wipe_store();
    end
    o.used_entries = 11'(live_cnt);
    return o;
  endfunction

  // sender: bursts with random gaps
  span_req_t shown;
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_resps.push_back(span_store_step(shown));
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          shown = pending_reqs.pop_front();
          in_func <= shown.func;
          in_line_y <= shown.line_y;
          in_left_x <= shown.left_x;
          in_right_x <= shown.right_x;
          in_span_index <= shown.span_index;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  logic hold_req = 1'b0;
  logic long_hold = 1'b0;
  int   hold_cycles = 0;

  always @(posedge clk) begin
    if (hold_req && hold_cycles < 600) begin
      hold_cycles <= hold_cycles + 1;
      long_hold <= 1'b1;
    end else begin
      long_hold <= 1'b0;
    end
  end

  // receiver stall pattern
  int pat_cnt = 0;

  always @(posedge clk) begin
    pat_cnt <= pat_cnt + 1;
    case (pat_cnt[9:8])
      2'd0: out_ready <= !long_hold;
      2'd1: out_ready <= !long_hold && ($urandom_range(0, 3) != 0);
      2'd2: out_ready <= !long_hold && (pat_cnt[2:0] != 3'd0);
      default: out_ready <= !long_hold && ($urandom_range(0, 1) == 1);
    endcase
  end

  // result checker
  always @(posedge clk) begin
    span_resp_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_status, out_span_left, out_span_right, out_span_count,
             out_first_line, out_last_line, out_used_entries};
      if (expected_resps.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result transaction: %h", got);
      end else begin
        want = expected_resps.pop_front();
        n_checked++;
        if (got != want) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch #%0d: exp st=%0d l=%0d r=%0d cnt=%0d fl=%0d ll=%0d used=%0d / act st=%0d l=%0d r=%0d cnt=%0d fl=%0d ll=%0d used=%0d",
                     n_checked, want.status, $signed(want.span_left),
                     $signed(want.span_right), want.span_count,
                     $signed(want.first_line), $signed(want.last_line),
                     want.used_entries, got.status, $signed(got.span_left),
                     $signed(got.span_right), got.span_count,
                     $signed(got.first_line), $signed(got.last_line),
                     got.used_entries);
        end
      end
    end
  end

  int cycle_cnt = 0;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 10000000) begin
      $display("timeout with %0d transactions outstanding", expected_resps.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic queue_req(logic [2:0] f, int y, int l, int r, int idx);
    span_req_t q;
    q.func = f;
    q.line_y = 16'(y);
    q.left_x = 16'(l);
    q.right_x = 16'(r);
    q.span_index = 10'(idx);
    pending_reqs.push_back(q);
  endtask

  task automatic settle();
    while (pending_reqs.size() > 0 || in_valid || expected_resps.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_TOP_LINE) win_top = $signed(val);
    else win_lines = val & 16'h01ff;
    wipe_store();
    @(posedge clk);
  endtask

  task automatic set_window(int top, int lines);
    settle();
    write_reg(CFG_TOP_LINE, 16'(top));
    write_reg(CFG_LINE_COUNT, 16'(lines));
  endtask

  task automatic random_reqs(int count);
    int y, l, r, w, k;
    logic [2:0] f;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      if (k < 42) f = F_ADD;
      else if (k < 66) f = F_DEL;
      else if (k < 88) f = F_READ;
      else if (k < 95) f = F_RANGE;
      else if (k < 96) f = F_CLEAR;
      else f = 3'($urandom_range(5, 7));
      if ($urandom_range(0, 9) == 0) y = $signed(16'($urandom));
      else y = win_top + $urandom_range(0, 9) - 1;
      if ($urandom_range(0, 9) == 0) begin
        l = $signed(16'($urandom));
        r = $signed(16'($urandom));
      end else begin
        w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
        l = $urandom_range(0, 120) - 60;
        r = ($urandom_range(0, 19) == 0) ? l - 1 : l + w;
      end
      queue_req(f, y, l, r,
                ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 8));
    end
  endtask

  initial begin
    win_top = 0;
    win_lines = MAX_LINES;
    wipe_store();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    queue_req(F_ADD, 0, 10, 20, 0);
    queue_req(F_ADD, 0, 22, 30, 0);
    queue_req(F_ADD, 0, 21, 21, 0);
    queue_req(F_ADD, 0, 31, 35, 0);
    queue_req(F_ADD, 0, -5, 0, 0);
    queue_req(F_ADD, 0, -32768, -32768, 0);
    queue_req(F_ADD, 0, 32767, 32767, 0);
    queue_req(F_DEL, 0, 12, 14, 0);
    queue_req(F_DEL, 0, -100, -4, 0);
    queue_req(F_ADD, 0, 5, 1, 0);
    queue_req(F_DEL, 0, 30, 2, 0);
    queue_req(F_READ, 0, 0, 0, 0);
    queue_req(F_READ, 0, 0, 0, 1);
    queue_req(F_READ, 0, 0, 0, 5);
    queue_req(F_READ, 0, 0, 0, 1023);
    queue_req(F_ADD, -1, 0, 3, 0);
    queue_req(F_ADD, 256, 0, 3, 0);
    queue_req(F_READ, 255, -1, -1, 0);
    queue_req(F_RANGE, 0, 0, 0, 0);
    queue_req(3'd5, 0, 1, 2, 3);
    queue_req(3'd6, 0, -1, -1, 1023);
    queue_req(3'd7, -1, 0, 0, 0);
    queue_req(F_CLEAR, 0, 0, 0, 0);
    queue_req(F_RANGE, 0, 0, 0, 0);

    set_window(-32768, 1);
    queue_req(F_ADD, -32768, 1, 2, 0);
    queue_req(F_ADD, -32767, 1, 2, 0);
    random_reqs(30);
    set_window(32767, 511);
    random_reqs(30);
    queue_req(F_RANGE, 0, 0, 0, 0);
    set_window(100, 0);
    random_reqs(15);
    queue_req(F_RANGE, 0, 0, 0, 0);

    set_window(-3, 6);
    hold_req <= 1'b1;
    random_reqs(120);

    // fill the pool, then push on it while full
    set_window(0, 256);
    for (int k = 0; k < POOL_ENTRIES; k++)
      queue_req(F_ADD, k % 256, 4 * (k / 256), 4 * (k / 256) + 2, 0);
    queue_req(F_ADD, 7, 100, 101, 0);
    queue_req(F_DEL, 3, 5, 5, 0);
    queue_req(F_ADD, 7, 3, 3, 0);
    queue_req(F_DEL, 9, 0, 2, 0);
    queue_req(F_DEL, 9, 8, 10, 0);
    queue_req(F_ADD, 9, 40, 41, 0);
    queue_req(F_DEL, 3, 5, 5, 0);
    queue_req(F_DEL, 3, 13, 13, 0);
    queue_req(F_READ, 3, 0, 0, 2);
    queue_req(F_RANGE, 0, 0, 0, 0);
    settle();

    $display("%0d results checked over several window settings, %0d pool-full cases",
             n_checked, n_full);
    if (n_errors == 0 && expected_resps.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d failures, %0d results missing", n_errors, expected_resps.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
